// ----- rtl/binary_crossbar_masked_mvm_macros.svh -----
// Assertion macros shared by the crossbar matrix-vector block.
`ifndef BINARY_CROSSBAR_MASKED_MVM_MACROS_SVH
`define BINARY_CROSSBAR_MASKED_MVM_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BCM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define BCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define BCM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BCM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/bcm_pkg.sv -----
package bcm_pkg;

  localparam int RowFieldW = 6;
  localparam int ColFieldW = 6;
  localparam int DataW     = 64;
  localparam int CountW    = 7;

  localparam logic CmdLoad    = 1'b0;
  localparam logic CmdCompute = 1'b1;

  // One queued request: a compute carries row select in data_a and the mask
  // in data_b, a load carries the weight row in data_a.
  typedef struct packed {
    logic                 is_compute;
    logic [RowFieldW-1:0] row;
    logic [DataW-1:0]     data_a;
    logic [DataW-1:0]     data_b;
  } bcm_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_HOLD
  } bcm_state_t;

endpackage

// ----- rtl/bcm_ram.sv -----
module bcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bcm_front.sv -----
module bcm_front #(
  parameter int ROWS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_ready,
  input  logic                                  cmd,
  input  logic [bcm_pkg::RowFieldW-1:0]         row_number,
  input  logic [bcm_pkg::DataW-1:0]             weight_row,
  input  logic [bcm_pkg::DataW-1:0]             row_select,
  input  logic [bcm_pkg::DataW-1:0]             column_mask,
  output logic                                  req_valid,
  output bcm_pkg::bcm_req_t                     req,
  input  logic                                  req_pop
);

  bcm_pkg::bcm_req_t entry [2];
  bcm_pkg::bcm_req_t incoming;
  logic              wptr;
  logic              rptr;
  logic [1:0]        fill;
  logic              keep;
  logic              push;

  // Loads to rows beyond the matrix are dropped here and never queued.
  assign keep = (cmd == bcm_pkg::CmdCompute) ||
                ({1'b0, row_number} < (bcm_pkg::RowFieldW + 1)'(ROWS));

  assign item_ready = (fill != 2'd2);
  assign push       = item_valid && item_ready && keep;
  assign req_valid  = (fill != 2'd0);
  assign req        = entry[rptr];

  always_comb begin
    incoming.is_compute = (cmd == bcm_pkg::CmdCompute);
    incoming.row        = row_number;
    incoming.data_a     = (cmd == bcm_pkg::CmdCompute) ? row_select : weight_row;
    incoming.data_b     = column_mask;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (req_pop) begin
        rptr <= ~rptr;
      end
      case ({push, req_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- rtl/bcm_back.sv -----
`include "binary_crossbar_masked_mvm_macros.svh"

module bcm_back #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  input  bcm_pkg::bcm_req_t                     req,
  output logic                                  req_pop,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [bcm_pkg::ColFieldW-1:0]         column_number,
  output logic [bcm_pkg::CountW-1:0]            column_count,
  output logic                                  last_column
);

  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColW = (COLS > 1) ? $clog2(COLS) : 1;

  bcm_pkg::bcm_state_t state;
  bcm_pkg::bcm_state_t state_next;

  logic                       ram_we;
  logic                       ram_re;
  logic                       start;
  logic                       handoff;
  logic                       load_out;
  logic [COLS-1:0]            ram_q;
  logic [RowW-1:0]            ridx;
  logic [RowW-1:0]            rd_row;
  logic                       rd_valid;
  logic [ROWS-1:0]            rsel;
  logic [COLS-1:0]            mask;
  logic [bcm_pkg::CountW-1:0] acc [COLS];
  logic [bcm_pkg::CountW-1:0] sh [COLS];
  logic                       emit_busy;
  logic [ColW-1:0]            emit_col;

  bcm_ram #(
    .WIDTH(COLS),
    .DEPTH(ROWS)
  ) u_weights (
    .clk  (clk),
    .we   (ram_we),
    .waddr(req.row[RowW-1:0]),
    .wdata(req.data_a[COLS-1:0]),
    .re   (ram_re),
    .raddr(ridx),
    .rdata(ram_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      bcm_pkg::ST_IDLE: begin
        if (req_valid && req.is_compute) begin
          state_next = bcm_pkg::ST_SWEEP;
        end
      end
      bcm_pkg::ST_SWEEP: begin
        if (ridx == RowW'(ROWS - 1)) begin
          state_next = bcm_pkg::ST_DRAIN;
        end
      end
      bcm_pkg::ST_DRAIN: state_next = bcm_pkg::ST_HOLD;
      bcm_pkg::ST_HOLD: begin
        if (!emit_busy) begin
          state_next = bcm_pkg::ST_IDLE;
        end
      end
      default: state_next = bcm_pkg::ST_IDLE;
    endcase
  end

  // Requests leave the queue only while idle, so a load queued behind a
  // compute cannot change rows that the compute still has to read.
  always_comb begin
    req_pop = 1'b0;
    ram_re  = 1'b0;
    handoff = 1'b0;
    case (state)
      bcm_pkg::ST_IDLE:  req_pop = req_valid;
      bcm_pkg::ST_SWEEP: ram_re  = 1'b1;
      bcm_pkg::ST_HOLD:  handoff = !emit_busy;
      default: begin
        req_pop = 1'b0;
      end
    endcase
  end

  assign ram_we   = req_pop && !req.is_compute;
  assign start    = req_pop && req.is_compute;
  assign load_out = emit_busy && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bcm_pkg::ST_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rsel <= req.data_a[ROWS-1:0];
      mask <= req.data_b[COLS-1:0];
      ridx <= '0;
    end else if (ram_re) begin
      ridx <= ridx + RowW'(1);
    end
    rd_row <= ridx;
  end

  // One weight row arrives per cycle; every column lane counts it in place.
  for (genvar c = 0; c < COLS; c++) begin : g_lane
    always_ff @(posedge clk) begin
      if (start) begin
        acc[c] <= '0;
      end else if (rd_valid && rsel[rd_row] && mask[c] && ram_q[c]) begin
        acc[c] <= acc[c] + bcm_pkg::CountW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (handoff) begin
        sh[c] <= acc[c];
      end else if (load_out) begin
        if (c < COLS - 1) begin
          sh[c] <= sh[(c < COLS - 1) ? c + 1 : c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_busy    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (handoff) begin
        emit_busy <= 1'b1;
      end else if (load_out && (emit_col == ColW'(COLS - 1))) begin
        emit_busy <= 1'b0;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      emit_col <= '0;
    end else if (load_out) begin
      emit_col <= emit_col + ColW'(1);
    end
    if (load_out) begin
      column_count  <= sh[0];
      column_number <= bcm_pkg::ColFieldW'(emit_col);
      last_column   <= (emit_col == ColW'(COLS - 1));
    end
  end

  `BCM_ASSERT_IMPLY(a_no_pop_in_sweep, clk, rst, state == bcm_pkg::ST_SWEEP, !req_pop)
  `BCM_ASSERT_IMPLY(a_last_is_final_col, clk, rst, result_valid && last_column, column_number == bcm_pkg::ColFieldW'(COLS - 1))
  `BCM_ASSERT_NEXT(a_cols_in_order, clk, rst, result_valid && result_ready && !last_column, result_valid && column_number == bcm_pkg::ColFieldW'($past(column_number) + 1))

endmodule

// ----- rtl/binary_crossbar_masked_mvm.sv -----
// Binary crossbar matrix-vector multiply with row select and column mask.
// Input channel (item_valid/item_ready): cmd selects a load, which writes
// weight_row into row row_number, or a compute, which brings row_select
// and column_mask. A load gives no result; a load to a row past ROWS is
// dropped. A compute gives COLS results on the result channel
// (result_valid/result_ready), one per column in order, with last_column
// set on the final one. Each request is taken into a two-entry queue. A
// compute sweeps the weight memory one row per cycle through its single
// read port, then hands its column counts to an output shifter that sends
// one result per cycle while the receiver is ready. The next sweep runs
// while results drain. Reset empties the queue and the output; weight
// rows keep no reset value and must be loaded before a compute reads
// them. When the receiver stalls the result register holds, the shifter
// waits, and the queue fills until item_ready drops.
module binary_crossbar_masked_mvm #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          cmd,
  input  logic [bcm_pkg::RowFieldW-1:0] row_number,
  input  logic [bcm_pkg::DataW-1:0]     weight_row,
  input  logic [bcm_pkg::DataW-1:0]     row_select,
  input  logic [bcm_pkg::DataW-1:0]     column_mask,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [bcm_pkg::ColFieldW-1:0] column_number,
  output logic [bcm_pkg::CountW-1:0]    column_count,
  output logic                          last_column
);

  bcm_pkg::bcm_req_t req;
  logic              req_valid;
  logic              req_pop;

  bcm_front #(
    .ROWS(ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .row_number (row_number),
    .weight_row (weight_row),
    .row_select (row_select),
    .column_mask(column_mask),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop)
  );

  bcm_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req          (req),
    .req_pop      (req_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .column_number(column_number),
    .column_count (column_count),
    .last_column  (last_column)
  );

endmodule
